// ===== hw/rtl/graph_traversal_bfs_dfs_assert.svh =====
// Assertion macros shared by the graph traversal RTL.
// Used by gt_front and gt_engine; no other dependencies.
`ifndef GRAPH_TRAVERSAL_BFS_DFS_ASSERT_SVH
`define GRAPH_TRAVERSAL_BFS_DFS_ASSERT_SVH

// invariant checked at every clock edge out of reset
`define GT_ASSERT(lbl, ck, rn, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) else $error(msg);

// cause in one cycle, effect in the next
`define GT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/gt_pkg.sv =====
// Types and constants for the graph traversal block.
// No dependencies; imported by gt_front, gt_engine and the top level.
package gt_pkg;

  localparam int MAX_RESULTS   = 16;
  localparam int OUT_NAME_BITS = 8;
  localparam int MAX_NAME_BITS = 16;

  typedef enum logic [1:0] {
    OP_CLEAR      = 2'd0,
    OP_ADD_VERTEX = 2'd1,
    OP_ADD_EDGE   = 2'd2,
    OP_TRAVERSE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_DUP     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_SRCH,
    S_SCMP,
    S_DECIDE,
    S_POP,
    S_VCHK,
    S_VISIT,
    S_ESCAN,
    S_ECHK,
    S_FINISH
  } eng_state_t;

  typedef struct packed {
    op_t                      op;
    logic [MAX_NAME_BITS-1:0] a;
    logic [MAX_NAME_BITS-1:0] b;
  } cmd_t;

  typedef struct packed {
    logic [OUT_NAME_BITS-1:0] name;
    status_t                  status;
    logic                     last;
  } res_t;

endpackage

// ===== hw/rtl/gt_front.sv =====
// Front end: accepts input beats, decodes them into commands and holds
// them in a two-entry queue. Depends on gt_pkg and the assert macros.
`include "graph_traversal_bfs_dfs_assert.svh"

module gt_front import gt_pkg::*; #(
  parameter int NAME_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [NAME_BITS-1:0] in_first,
  input  logic [NAME_BITS-1:0] in_second,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  logic                 cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       dec;

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    dec.op = op_t'(in_op);
    dec.a  = MAX_NAME_BITS'(in_first);
    dec.b  = MAX_NAME_BITS'(in_second);
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, cmd_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `GT_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= 2'd2, "queue count out of range")
  `GT_ASSERT(a_pop_nonempty, clk, rst_n, !cmd_pop || cnt_r != 2'd0, "pop from empty queue")
  `GT_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !cmd_pop && cnt_r == 2'd0,
    cnt_r == 2'd1, "push into empty queue lost")

endmodule

// ===== hw/rtl/gt_engine.sv =====
// Back end: vertex and edge stores, search, and BFS/DFS traversal with a
// shared work list memory and an output register. Depends on gt_pkg.
`include "graph_traversal_bfs_dfs_assert.svh"

module gt_engine import gt_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_EDGES    = 64,
  parameter int NAME_BITS    = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic mode,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic out_ready,
  output logic out_valid,
  output res_t out_res
);

  localparam int VI_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VT_W = $clog2(MAX_VERTICES + 1);
  localparam int EI_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET_W = $clog2(MAX_EDGES + 1);
  localparam int WI_W = $clog2(MAX_EDGES + 1);
  localparam int WT_W = $clog2(MAX_EDGES + 2);
  localparam int RC_W = $clog2(MAX_RESULTS + 1);

  eng_state_t state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic [NAME_BITS-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [VT_W-1:0] i_r, i_nxt, vtot_r, vtot_nxt;
  logic fa_r, fa_nxt, fb_r, fb_nxt;
  logic [VI_W-1:0] ia_r, ia_nxt, ib_r, ib_nxt, v_r, v_nxt;
  status_t status_r, status_nxt;
  logic [ET_W-1:0] etot_r, etot_nxt, e_r, e_nxt;
  logic [WT_W-1:0] head_r, head_nxt, tail_r, tail_nxt, tail_m1;
  logic [RC_W-1:0] nres_r, nres_nxt;
  logic pend_v_r, pend_v_nxt, dfs_r, dfs_nxt;
  logic [NAME_BITS-1:0] pend_name_r, pend_name_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  // memories
  logic [NAME_BITS-1:0] vname_mem [MAX_VERTICES];
  logic [2*VI_W-1:0]    edge_mem  [MAX_EDGES];
  logic [VI_W-1:0]      work_mem  [MAX_EDGES+1];
  logic [NAME_BITS-1:0] vname_rd_r;
  logic [2*VI_W-1:0]    edge_rd_r;
  logic [VI_W-1:0]      work_rd_r;

  logic vname_we, vname_re, edge_we, edge_re, work_we, work_re;
  logic [VI_W-1:0] vname_wa, vname_ra;
  logic [EI_W-1:0] edge_wa;
  logic [WI_W-1:0] work_wa, work_ra;
  logic [VI_W-1:0] work_wd, e_src, e_tgt;
  logic out_free;
  logic [MAX_NAME_BITS-1:0] pend_wide;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign tail_m1   = tail_r - WT_W'(1);
  assign e_src     = edge_rd_r[2*VI_W-1:VI_W];
  assign e_tgt     = edge_rd_r[VI_W-1:0];
  assign pend_wide = MAX_NAME_BITS'(pend_name_r);
  assign vname_ra  = (state_r == S_SRCH) ? i_r[VI_W-1:0] : work_rd_r;
  assign work_ra   = dfs_r ? tail_m1[WI_W-1:0] : head_r[WI_W-1:0];

  always_ff @(posedge clk) begin
    if (vname_we) vname_mem[vname_wa] <= a_r;
    if (vname_re) vname_rd_r <= vname_mem[vname_ra];
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= {ia_r, ib_r};
    if (edge_re) edge_rd_r <= edge_mem[e_r[EI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (work_we) work_mem[work_wa] <= work_wd;
    if (work_re) work_rd_r <= work_mem[work_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vtot_r      <= '0;
      etot_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      nres_r      <= '0;
      pend_v_r    <= 1'b0;
      dfs_r       <= 1'b0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
      op_r        <= OP_CLEAR;
      status_r    <= ST_OK;
      i_r         <= '0;
      e_r         <= '0;
      fa_r        <= 1'b0;
      fb_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vtot_r      <= vtot_nxt;
      etot_r      <= etot_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nres_r      <= nres_nxt;
      pend_v_r    <= pend_v_nxt;
      dfs_r       <= dfs_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      status_r    <= status_nxt;
      i_r         <= i_nxt;
      e_r         <= e_nxt;
      fa_r        <= fa_nxt;
      fb_r        <= fb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    ia_r        <= ia_nxt;
    ib_r        <= ib_nxt;
    v_r         <= v_nxt;
    pend_name_r <= pend_name_nxt;
    out_res_r   <= out_res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    i_nxt         = i_r;
    vtot_nxt      = vtot_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    v_nxt         = v_r;
    status_nxt    = status_r;
    etot_nxt      = etot_r;
    e_nxt         = e_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    nres_nxt      = nres_r;
    pend_v_nxt    = pend_v_r;
    pend_name_nxt = pend_name_r;
    dfs_nxt       = dfs_r;
    visited_nxt   = visited_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    cmd_pop       = 1'b0;
    vname_we      = 1'b0;
    vname_re      = 1'b0;
    vname_wa      = vtot_r[VI_W-1:0];
    edge_we       = 1'b0;
    edge_re       = 1'b0;
    edge_wa       = etot_r[EI_W-1:0];
    work_we       = 1'b0;
    work_re       = 1'b0;
    work_wa       = tail_r[WI_W-1:0];
    work_wd       = ia_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          op_nxt  = cmd.op;
          a_nxt   = cmd.a[NAME_BITS-1:0];
          b_nxt   = cmd.b[NAME_BITS-1:0];
          i_nxt   = '0;
          fa_nxt  = 1'b0;
          fb_nxt  = 1'b0;
          if (cmd.op == OP_CLEAR) begin
            vtot_nxt   = '0;
            etot_nxt   = '0;
            status_nxt = ST_OK;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{name: '0, status: status_r, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      S_SRCH: begin
        if (i_r < vtot_r) begin
          vname_re  = 1'b1;
          state_nxt = S_SCMP;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_SCMP: begin
        if (!fa_r && vname_rd_r == a_r) begin
          fa_nxt = 1'b1;
          ia_nxt = i_r[VI_W-1:0];
        end
        if (!fb_r && vname_rd_r == b_r) begin
          fb_nxt = 1'b1;
          ib_nxt = i_r[VI_W-1:0];
        end
        i_nxt     = i_r + VT_W'(1);
        state_nxt = S_SRCH;
      end
      S_DECIDE: begin
        state_nxt = S_EMIT;
        case (op_r)
          OP_ADD_VERTEX: begin
            if (fa_r) status_nxt = ST_DUP;
            else if (vtot_r == VT_W'(MAX_VERTICES)) status_nxt = ST_FULL;
            else begin
              vname_we   = 1'b1;
              vtot_nxt   = vtot_r + VT_W'(1);
              status_nxt = ST_OK;
            end
          end
          OP_ADD_EDGE: begin
            if (!fa_r || !fb_r) status_nxt = ST_UNKNOWN;
            else if (etot_r == ET_W'(MAX_EDGES)) status_nxt = ST_FULL;
            else begin
              edge_we    = 1'b1;
              etot_nxt   = etot_r + ET_W'(1);
              status_nxt = ST_OK;
            end
          end
          OP_TRAVERSE: begin
            if (!fa_r) begin
              status_nxt = ST_UNKNOWN;
            end else begin
              work_we     = 1'b1;
              work_wa     = '0;
              work_wd     = ia_r;
              head_nxt    = '0;
              tail_nxt    = WT_W'(1);
              nres_nxt    = '0;
              pend_v_nxt  = 1'b0;
              dfs_nxt     = mode;
              visited_nxt = '0;
              // BFS marks on enqueue, so the start is marked now
              if (!mode) visited_nxt[ia_r] = 1'b1;
              state_nxt   = S_POP;
            end
          end
          default: status_nxt = ST_OK;
        endcase
      end
      S_POP: begin
        if ((dfs_r ? (tail_r != '0) : (head_r < tail_r)) &&
            (nres_r < RC_W'(MAX_RESULTS))) begin
          work_re = 1'b1;
          if (dfs_r) tail_nxt = tail_m1;
          else head_nxt = head_r + WT_W'(1);
          state_nxt = S_VCHK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_VCHK: begin
        v_nxt = work_rd_r;
        if (dfs_r && visited_r[work_rd_r]) begin
          state_nxt = S_POP;
        end else begin
          vname_re  = 1'b1;
          state_nxt = S_VISIT;
        end
      end
      S_VISIT: begin
        // previous visit goes out only now that we know it is not the last
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = '{name: pend_wide[OUT_NAME_BITS-1:0], status: ST_OK,
                              last: 1'b0};
          end
          pend_v_nxt    = 1'b1;
          pend_name_nxt = vname_rd_r;
          nres_nxt      = nres_r + RC_W'(1);
          if (dfs_r) visited_nxt[v_r] = 1'b1;
          e_nxt         = '0;
          state_nxt     = S_ESCAN;
        end
      end
      S_ESCAN: begin
        if (e_r < etot_r) begin
          edge_re   = 1'b1;
          state_nxt = S_ECHK;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_ECHK: begin
        work_wd = e_tgt;
        if (e_src == v_r) begin
          if (dfs_r || !visited_r[e_tgt]) begin
            if (!dfs_r) visited_nxt[e_tgt] = 1'b1;
            if (tail_r < WT_W'(MAX_EDGES + 1)) begin
              work_we  = 1'b1;
              tail_nxt = tail_r + WT_W'(1);
            end
          end
        end
        e_nxt     = e_r + ET_W'(1);
        state_nxt = S_ESCAN;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{name: pend_wide[OUT_NAME_BITS-1:0], status: ST_OK,
                            last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `GT_ASSERT(a_vtot_range, clk, rst_n, vtot_r <= VT_W'(MAX_VERTICES),
    "vertex count overflow")
  `GT_ASSERT(a_tail_range, clk, rst_n, tail_r <= WT_W'(MAX_EDGES + 1),
    "work list overflow")
  `GT_ASSERT_NEXT(a_finish_last, clk, rst_n, state_r == S_FINISH && out_free,
    out_valid_r && out_res_r.last, "traversal end without last beat")

endmodule

// ===== hw/rtl/graph_traversal_bfs_dfs.sv =====
// Graph store with BFS/DFS traversal. A load item compares the names of
// all V stored vertices in turn, each read in S_SRCH and compared in S_SCMP;
// a traversal scans all E stored edges in the single-port edge memory
// per visited vertex, and a revisited DFS pop is dropped in S_VCHK.
// One item is worked at a time. Reset (rst_n low, synchronous) empties the
// graph and sets BFS mode; memories keep contents, no clearing pass.
module graph_traversal_bfs_dfs import gt_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_EDGES    = 64,
  parameter int NAME_BITS    = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // op, first_name, second_name, zero pad
  input  logic [((2*NAME_BITS+2+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // visited_name, status, zero pad
  output logic [15:0] out_tdata,
  output logic out_tlast,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data
);

  logic mode_r;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_wr_en) mode_r <= cfg_wr_data;
  end

  gt_front #(.NAME_BITS(NAME_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tdata[1:0]),
    .in_first  (in_tdata[2 +: NAME_BITS]),
    .in_second (in_tdata[2+NAME_BITS +: NAME_BITS]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  gt_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .NAME_BITS    (NAME_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (res)
  );

  assign out_tdata = {6'b0, res.status, res.name};
  assign out_tlast = res.last;

endmodule
